// ===== hw/rtl/asc_pkg.sv =====
// ----------------------------------------------------------------------------
// asc_pkg: shared types and constants for the averaged sample capture unit
// Request payload types, register indexes and fixed sizes of the datapath.
// ----------------------------------------------------------------------------
package asc_pkg;

    // Field widths
    localparam int SampleBits    = 12;
    localparam int FracBits      = 8;
    localparam int AvgBits       = SampleBits + FracBits;
    localparam int WeightBits    = 16;
    localparam int AccBits       = AvgBits + WeightBits;
    localparam int IndexBits     = 10;
    localparam int SinceLastBits = 17;
    localparam int ElapsedBits   = 32;

    // Capture limits
    localparam int CaptureLength = 1000;
    localparam int MinInterval   = 30;

    // Operation codes of an input request
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_AVERAGE_COUNT = 1'b0,
        CFG_SAMPLE_INTERVAL = 1'b1
    } t_cfg_idx;

    // Input request
    typedef struct packed {
        logic [1:0]            operation;
        logic [SampleBits-1:0] sample_value;
    } t_in_req;

    // Result request
    typedef struct packed {
        logic [SampleBits-1:0]  average_reading;
        logic                   capture_active;
        logic                   record_valid;
        logic [IndexBits-1:0]   record_index;
        logic [ElapsedBits-1:0] record_elapsed_us;
        logic [SampleBits-1:0]  record_value;
        logic                   record_last;
    } t_out_req;

endpackage

// ===== hw/rtl/averaged_sample_capture_unit.sv =====
// ----------------------------------------------------------------------------
// averaged_sample_capture_unit: running average with timed record capture
// Keeps a fixed point running average of converter samples and emits timed
// records of it, paced by microsecond tick requests after a start request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one request:
//   a sample, a microsecond tick or a start. Every request gives exactly one
//   result on the output channel (o_out_valid / i_out_stall / o_out_data).
//   Configuration writes (i_cfg_valid / o_cfg_ready) set the averaging
//   weight N (index 0) and the record interval (index 1); ready is always
//   high, and writes are expected only while the block is idle.
//   Sequence: a sample's multiply-add is registered at accept, the divider
//   is loaded in S_DIV_START, runs its 20 steps in S_DIV_WAIT and registers
//   its done flag, and the result commits from S_DONE; a tick or start goes
//   from accept straight to S_DONE. A commit waits while the output register
//   is still held by i_out_stall.
//   One request is in work at a time; o_in_stall is high until the result
//   has been loaded into the output register.
//   A result held by i_out_stall stays in the output register; the next
//   request may be accepted and worked, and waits to commit until the
//   register frees up.
//   Reset clears the average, the capture state and counters, and loads
//   N = 10 and interval = 0.
// ----------------------------------------------------------------------------
module averaged_sample_capture_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input requests
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  asc_pkg::t_in_req     i_in_data,
    // result requests
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output asc_pkg::t_out_req    o_out_data,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  asc_pkg::t_cfg_idx    i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_START,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    localparam int CntSumBits = asc_pkg::IndexBits + 1;

    t_state                              r_state;
    logic [1:0]                          r_op;
    logic [asc_pkg::AccBits-1:0]         r_acc;
    logic [asc_pkg::AvgBits-1:0]         r_avg;
    logic                                r_capturing;
    logic [asc_pkg::IndexBits-1:0]       r_rec_cnt;
    logic [asc_pkg::SinceLastBits-1:0]   r_since_last;
    logic [asc_pkg::ElapsedBits-1:0]     r_since_start;
    logic [asc_pkg::WeightBits-1:0]      r_avg_count;
    logic [15:0]                         r_interval;
    logic                                r_out_valid;
    asc_pkg::t_out_req                   r_out_data;

    logic                                w_accept;
    logic                                w_slot_free;
    logic                                w_commit;
    logic [asc_pkg::WeightBits-1:0]      w_weight;
    logic [asc_pkg::WeightBits-1:0]      w_weight_m1;
    logic [asc_pkg::AccBits-1:0]         w_product;
    logic                                w_div_start;
    logic                                w_div_done;
    logic [asc_pkg::AvgBits-1:0]         w_quotient;

    logic [asc_pkg::AvgBits-1:0]         n_avg;
    logic                                n_capturing;
    logic [asc_pkg::IndexBits-1:0]       n_rec_cnt;
    logic [asc_pkg::SinceLastBits-1:0]   n_since_last;
    logic [asc_pkg::ElapsedBits-1:0]     n_since_start;
    asc_pkg::t_out_req                   n_out_data;

    logic                                w_interval_ok;
    logic [asc_pkg::SinceLastBits-1:0]   w_last_inc;
    logic [asc_pkg::ElapsedBits-1:0]     w_start_inc;
    logic [CntSumBits-1:0]               w_cnt_inc;

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_commit    = (r_state == S_DONE) && w_slot_free;
    assign w_div_start = (r_state == S_DIV_START);

    // Weight N with zero taken as one, and the multiply-add term
    assign w_weight    = (r_avg_count == '0) ? asc_pkg::WeightBits'(1) : r_avg_count;
    assign w_weight_m1 = w_weight - asc_pkg::WeightBits'(1);
    assign w_product   = asc_pkg::AccBits'(r_avg) * asc_pkg::AccBits'(w_weight_m1)
                       + asc_pkg::AccBits'({i_in_data.sample_value,
                                            asc_pkg::FracBits'(0)});

    asc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_acc),
        .i_divisor  (w_weight),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Helpers for tick handling
    assign w_interval_ok = (r_interval >= 16'(asc_pkg::MinInterval));
    assign w_last_inc    = (r_since_last == '1) ? r_since_last
                                                : r_since_last + asc_pkg::SinceLastBits'(1);
    assign w_start_inc   = r_since_start + asc_pkg::ElapsedBits'(1);
    assign w_cnt_inc     = CntSumBits'(r_rec_cnt) + CntSumBits'(1);

    // Outcome of the request in work, committed in S_DONE
    always_comb begin
        n_avg         = r_avg;
        n_capturing   = r_capturing;
        n_rec_cnt     = r_rec_cnt;
        n_since_last  = r_since_last;
        n_since_start = r_since_start;
        n_out_data    = '0;

        case (r_op)
            asc_pkg::OP_SAMPLE: begin
                n_avg = w_quotient;
            end
            asc_pkg::OP_TICK: begin
                if (r_capturing) begin
                    if (!w_interval_ok) begin
                        n_capturing = 1'b0;
                    end else begin
                        n_since_last  = w_last_inc;
                        n_since_start = w_start_inc;
                        if (w_last_inc > asc_pkg::SinceLastBits'(r_interval)) begin
                            n_since_last                 = '0;
                            n_out_data.record_valid      = 1'b1;
                            n_out_data.record_index      = r_rec_cnt;
                            n_out_data.record_elapsed_us = w_start_inc;
                            n_out_data.record_value      =
                                r_avg[asc_pkg::AvgBits-1:asc_pkg::FracBits];
                            n_rec_cnt = w_cnt_inc[asc_pkg::IndexBits-1:0];
                            if (w_cnt_inc >= CntSumBits'(asc_pkg::CaptureLength)) begin
                                n_out_data.record_last = 1'b1;
                                n_capturing            = 1'b0;
                                n_rec_cnt              = '0;
                            end
                        end
                    end
                end
            end
            asc_pkg::OP_START: begin
                if (!w_interval_ok) begin
                    n_capturing = 1'b0;
                end else if (!r_capturing) begin
                    n_capturing   = 1'b1;
                    n_rec_cnt     = '0;
                    n_since_last  = '0;
                    n_since_start = '0;
                end
            end
            default: begin
                // unused code: status only
            end
        endcase

        n_out_data.average_reading = n_avg[asc_pkg::AvgBits-1:asc_pkg::FracBits];
        n_out_data.capture_active  = n_capturing;
    end

    // Sequencer, block state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_avg         <= '0;
            r_capturing   <= 1'b0;
            r_rec_cnt     <= '0;
            r_since_last  <= '0;
            r_since_start <= '0;
            r_avg_count   <= 16'd10;
            r_interval    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    asc_pkg::CFG_AVERAGE_COUNT:   r_avg_count <= i_cfg_data;
                    asc_pkg::CFG_SAMPLE_INTERVAL: r_interval  <= i_cfg_data;
                endcase
            end

            // output register: loaded on commit, drains when taken
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op <= i_in_data.operation;
                        if (i_in_data.operation == asc_pkg::OP_SAMPLE) begin
                            r_acc   <= w_product;
                            r_state <= S_DIV_START;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV_START: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_commit) begin
                        r_avg         <= n_avg;
                        r_capturing   <= n_capturing;
                        r_rec_cnt     <= n_rec_cnt;
                        r_since_last  <= n_since_last;
                        r_since_start <= n_since_start;
                        r_out_data    <= n_out_data;
                        r_state       <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== hw/rtl/asc_div.sv =====
// ----------------------------------------------------------------------------
// asc_div: serial restoring divider for the running average
// Divides the weighted sum by N one quotient bit per cycle. The quotient is
// known to fit the average width, so the upper dividend bits seed the
// partial remainder and only AvgBits steps are needed.
// ----------------------------------------------------------------------------
module asc_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [asc_pkg::AccBits-1:0]        i_dividend,
    input  logic [asc_pkg::WeightBits-1:0]     i_divisor,
    output logic                               o_done,
    output logic [asc_pkg::AvgBits-1:0]        o_quotient
);

    localparam int CntBits = $clog2(asc_pkg::AvgBits + 1);

    logic [asc_pkg::WeightBits-1:0] r_rem;
    logic [asc_pkg::AvgBits-1:0]    r_dvd;
    logic [CntBits-1:0]             r_cnt;
    logic                           r_done;

    logic [asc_pkg::WeightBits:0]   w_shift;
    logic [asc_pkg::WeightBits:0]   w_trial;
    logic                           w_fit;

    // Trial subtract of the shifted remainder
    assign w_shift = {r_rem, r_dvd[asc_pkg::AvgBits-1]};
    assign w_trial = w_shift - {1'b0, i_divisor};
    assign w_fit   = (w_shift >= {1'b0, i_divisor});

    // Control counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CntBits'(asc_pkg::AvgBits);
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CntBits'(1));
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CntBits'(1);
            end
        end
    end

    // Datapath: remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[asc_pkg::AccBits-1:asc_pkg::AvgBits];
            r_dvd <= i_dividend[asc_pkg::AvgBits-1:0];
        end else if (r_cnt != '0) begin
            // when the trial fails the shifted value is below N, so it fits
            r_rem <= w_fit ? w_trial[asc_pkg::WeightBits-1:0]
                           : w_shift[asc_pkg::WeightBits-1:0];
            r_dvd <= {r_dvd[asc_pkg::AvgBits-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

// ===== tb/asc_result_checker.sv =====
// ----------------------------------------------------------------------------
// asc_result_checker: result prediction and comparison for the capture unit
// Watches the input, result and configuration channels of the averaged
// sample capture unit. It keeps its own copy of the average, the capture
// counters and the registers, predicts one result request per accepted input
// request, and compares every accepted result request field by field.
// ----------------------------------------------------------------------------
module asc_result_checker import asc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input requests
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_req     i_in_data,
    // result requests
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_req    i_out_data,
    // configuration writes
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  t_cfg_idx    i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // status towards the testbench top
    output int          o_fail_count,
    output int          o_pending
);

    // Shadow registers
    logic [WeightBits-1:0]    avg_weight;
    logic [15:0]              interval_us;

    // Shadow datapath state
    logic [AvgBits-1:0]       avg_fixed;
    logic                     capturing;
    logic [IndexBits-1:0]     rec_count;
    logic [SinceLastBits-1:0] since_last;
    logic [ElapsedBits-1:0]   since_start;

    // Predicted result requests, oldest first
    t_out_req status_fifo[$];
    t_out_req want;

    // Apply one input request to the shadow state and return its result
    function automatic t_out_req advance_capture(t_in_req req);
        t_out_req              res;
        logic [WeightBits-1:0] weight;
        logic [AccBits-1:0]    acc;
        logic [AccBits-1:0]    quot;
        res = '0;
        case (req.operation)
            OP_SAMPLE: begin
                // weight of zero behaves as one
                weight = (avg_weight == '0) ? 16'd1 : avg_weight;
                acc = {{WeightBits{1'b0}}, avg_fixed} * {{AvgBits{1'b0}}, weight - 1'b1}
                    + {{WeightBits{1'b0}}, req.sample_value, {FracBits{1'b0}}};
                quot = acc / {{AvgBits{1'b0}}, weight};
                avg_fixed = quot[AvgBits-1:0];
            end
            OP_TICK: begin
                if (capturing) begin
                    if (interval_us < MinInterval) begin
                        // interval lowered under a running capture
                        capturing = 1'b0;
                    end else begin
                        if (since_last != '1) since_last = since_last + 1'b1;
                        since_start = since_start + 1'b1;
                        if (since_last > {1'b0, interval_us}) begin
                            since_last            = '0;
                            res.record_valid      = 1'b1;
                            res.record_index      = rec_count;
                            res.record_elapsed_us = since_start;
                            res.record_value      = avg_fixed[AvgBits-1:FracBits];
                            rec_count             = rec_count + 1'b1;
                            if (rec_count >= CaptureLength) begin
                                res.record_last = 1'b1;
                                capturing       = 1'b0;
                                rec_count       = '0;
                            end
                        end
                    end
                end
            end
            OP_START: begin
                if (interval_us < MinInterval) begin
                    capturing = 1'b0;
                end else if (!capturing) begin
                    capturing   = 1'b1;
                    rec_count   = '0;
                    since_last  = '0;
                    since_start = '0;
                end
            end
            default: begin
                // unused code: status only
            end
        endcase
        res.average_reading = avg_fixed[AvgBits-1:FracBits];
        res.capture_active  = capturing;
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    // Channel monitor: result first, then the new input request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            avg_weight   = 16'd10;
            interval_us  = '0;
            avg_fixed    = '0;
            capturing    = 1'b0;
            rec_count    = '0;
            since_last   = '0;
            since_start  = '0;
            o_fail_count = 0;
            status_fifo.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_AVERAGE_COUNT:   avg_weight  = i_cfg_data;
                    CFG_SAMPLE_INTERVAL: interval_us = i_cfg_data;
                    default:             ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (status_fifo.size() == 0) begin
                    $error("result request with no prediction waiting");
                    o_fail_count++;
                end else begin
                    want = status_fifo.pop_front();
                    compare_field("average_reading", want.average_reading,
                                  i_out_data.average_reading);
                    compare_field("capture_active", want.capture_active,
                                  i_out_data.capture_active);
                    compare_field("record_valid", want.record_valid,
                                  i_out_data.record_valid);
                    compare_field("record_index", want.record_index,
                                  i_out_data.record_index);
                    compare_field("record_elapsed_us", want.record_elapsed_us,
                                  i_out_data.record_elapsed_us);
                    compare_field("record_value", want.record_value,
                                  i_out_data.record_value);
                    compare_field("record_last", want.record_last,
                                  i_out_data.record_last);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                status_fifo.push_back(advance_capture(i_in_data));
            end
        end
        o_pending = status_fifo.size();
    end

endmodule

// ===== tb/tb_averaged_sample_capture_unit.sv =====
// ----------------------------------------------------------------------------
// tb_averaged_sample_capture_unit: stimulus and verdict for the capture unit
// Drives directed and random sample, tick and start requests with random
// gaps and stalls on both sides, writes the registers between phases and
// reports the checker's outcome.
// ----------------------------------------------------------------------------
module tb_averaged_sample_capture_unit;
    import asc_pkg::*;

    // Code with no operation behind it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Receiver hold-off used to back up the block
    localparam int HoldAfter  = 300;
    localparam int HoldCycles = 250;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_req     in_data   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_req    out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    t_cfg_idx    cfg_index = CFG_AVERAGE_COUNT;
    logic [15:0] cfg_data  = '0;
    int          fail_count;
    int          pending;

    // Gap pattern state of each side
    int tx_streak = 0;
    bit tx_calm   = 1'b0;
    int rx_streak = 0;
    bit rx_calm   = 1'b0;
    int rx_gap    = 0;
    int rx_taken  = 0;
    bit rx_took;

    averaged_sample_capture_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    asc_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Run limit
    initial begin
        #200_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Idle cycles before one request; streaks of back-to-back traffic between
    function automatic int draw_gap(inout int streak, inout bit calm);
        if (streak == 0) begin
            streak = $urandom_range(8, 40);
            calm   = ($urandom_range(0, 2) == 0);
        end
        streak--;
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // Offer one input request; returns right after the accepting edge
    task automatic send_req(input logic [1:0] op, input logic [SampleBits-1:0] value);
        int gap;
        gap = draw_gap(tx_streak, tx_calm);
        @(negedge clk);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data.operation    = op;
        in_data.sample_value = value;
        in_valid             = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Stop offering and wait for every predicted result request
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // One register write
    task automatic write_cfg(input t_cfg_idx idx, input logic [15:0] value);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Receiver: stall for a drawn number of cycles after each result request
    initial begin
        forever begin
            @(posedge clk);
            rx_took = out_valid && !out_stall;
            @(negedge clk);
            if (rx_took) begin
                rx_taken++;
                // one long hold-off so the block fills up and stalls its input
                rx_gap = (rx_taken == HoldAfter) ? HoldCycles : draw_gap(rx_streak, rx_calm);
            end
            out_stall = (rx_gap != 0);
            if (rx_gap != 0) rx_gap--;
        end
    end

    // Stimulus
    initial begin : stimulus
        int pick;
        logic [1:0] op;
        logic [15:0] weight;
        logic [15:0] interval;

        rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // settings after reset: weight ten, interval zero
        send_req(OP_SAMPLE, 12'hFFF);
        send_req(OP_SAMPLE, 12'h000);
        send_req(OP_TICK, 12'hFFF);      // tick while idle
        send_req(OP_START, 12'h000);     // interval too short, no capture
        send_req(OP_UNUSED, 12'hFFF);

        // weight zero acts as one; interval at its minimum
        drain();
        write_cfg(CFG_AVERAGE_COUNT, 16'd0);
        write_cfg(CFG_SAMPLE_INTERVAL, 16'(MinInterval));
        send_req(OP_SAMPLE, 12'hFFF);
        send_req(OP_START, 12'h000);     // fresh start
        send_req(OP_START, 12'hFFF);     // ignored, capture runs on
        send_req(OP_TICK, 12'h000);
        send_req(OP_TICK, 12'hFFF);
        send_req(OP_SAMPLE, 12'h000);
        send_req(OP_UNUSED, 12'h000);

        // interval lowered under a running capture: next tick ends it
        drain();
        write_cfg(CFG_SAMPLE_INTERVAL, 16'(MinInterval - 1));
        send_req(OP_TICK, 12'h000);
        send_req(OP_START, 12'h000);

        // short-interval start clears a running capture
        drain();
        write_cfg(CFG_SAMPLE_INTERVAL, 16'(MinInterval));
        send_req(OP_START, 12'h000);
        drain();
        write_cfg(CFG_SAMPLE_INTERVAL, 16'(MinInterval - 1));
        send_req(OP_START, 12'h000);
        send_req(OP_TICK, 12'h000);

        // largest weight and interval
        drain();
        write_cfg(CFG_AVERAGE_COUNT, 16'hFFFF);
        write_cfg(CFG_SAMPLE_INTERVAL, 16'hFFFF);
        send_req(OP_SAMPLE, 12'hFFF);
        send_req(OP_SAMPLE, 12'hFFF);
        send_req(OP_START, 12'h000);
        send_req(OP_TICK, 12'h000);
        send_req(OP_TICK, 12'h000);
        drain();
        write_cfg(CFG_AVERAGE_COUNT, 16'd1);
        send_req(OP_SAMPLE, 12'h5A5);

        // random phases: a start, then mostly ticks with samples between
        for (int phase = 0; phase < 7; phase++) begin
            case ($urandom_range(0, 5))
                0:       weight = 16'd0;
                1:       weight = 16'd1;
                2:       weight = 16'hFFFF;
                3:       weight = 16'($urandom_range(2, 16));
                default: weight = 16'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 9))
                0:       interval = 16'($urandom_range(0, MinInterval - 1));
                1:       interval = 16'($urandom_range(0, 65535));
                2:       interval = 16'hFFFF;
                default: interval = 16'($urandom_range(MinInterval, MinInterval + 6));
            endcase
            drain();
            write_cfg(CFG_AVERAGE_COUNT, weight);
            write_cfg(CFG_SAMPLE_INTERVAL, interval);
            send_req(OP_START, 12'($urandom_range(0, 4095)));
            repeat (99) begin
                pick = $urandom_range(0, 99);
                if (pick < 74)      op = OP_TICK;
                else if (pick < 89) op = OP_SAMPLE;
                else if (pick < 95) op = OP_START;
                else                op = OP_UNUSED;
                send_req(op, 12'($urandom_range(0, 4095)));
            end
        end

        // wait out the last results and a latency margin for strays
        drain();
        repeat (48) @(negedge clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
